// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue package
// Sizes, request and status codes, and the command and status structs that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int PRIO_BITS   = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STAT_W      = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic    load;
        logic    insert;
        logic    remove;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/spq_if.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue channels
// Request and response channels, each with valid, ready and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [spq_pkg::PRIO_BITS-1:0] prio_value;
    logic [spq_pkg::TAG_BITS-1:0]  entry_tag;

    modport source (output valid, req_type, prio_value, entry_tag, input ready);
    modport sink   (input valid, req_type, prio_value, entry_tag, output ready);
endinterface

interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spq_pkg::STAT_W-1:0]   status;
    logic [spq_pkg::TAG_BITS-1:0] head_tag;
    logic [spq_pkg::CNT_W-1:0]    occupancy;

    modport source (output valid, status, head_tag, occupancy, input ready);
    modport sink   (input valid, status, head_tag, occupancy, output ready);
endinterface

`default_nettype wire

// ----- design/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue controller
// Tracks whether a response is held and decides what each request does.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire logic              i_req_type,
    input  wire logic              i_rsp_ready,
    input  wire spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd       o_cmd,
    output logic                   o_req_ready,
    output logic                   o_rsp_valid
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;
    logic            w_accept;

    always_comb begin
        o_req_ready = (r_state == spq_pkg::ST_IDLE) || i_rsp_ready;
        o_rsp_valid = (r_state == spq_pkg::ST_HOLD);
        w_accept    = i_req_valid && o_req_ready;
        o_cmd.load   = w_accept;
        o_cmd.insert = 1'b0;
        o_cmd.remove = 1'b0;
        o_cmd.status = spq_pkg::STAT_OK;
        if (i_req_type == spq_pkg::REQ_INSERT) begin
            if (i_stat.full) begin
                o_cmd.status = spq_pkg::STAT_FULL;
            end else begin
                o_cmd.insert = w_accept;
            end
        end else begin
            if (i_stat.empty) begin
                o_cmd.status = spq_pkg::STAT_EMPTY;
            end else begin
                o_cmd.remove = w_accept;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::ST_IDLE: begin
                if (i_req_valid) n_state = spq_pkg::ST_HOLD;
            end
            spq_pkg::ST_HOLD: begin
                if (i_rsp_ready && !i_req_valid) n_state = spq_pkg::ST_IDLE;
            end
            default: n_state = spq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- design/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue datapath
// A sorted shift-register queue with parallel compare, the fill count and
// the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire spq_pkg::t_dp_cmd              i_cmd,
    input  wire logic [spq_pkg::PRIO_BITS-1:0] i_prio,
    input  wire logic [spq_pkg::TAG_BITS-1:0]  i_tag,
    output spq_pkg::t_dp_stat                  o_stat,
    output logic [spq_pkg::STAT_W-1:0]         o_status,
    output logic [spq_pkg::TAG_BITS-1:0]       o_head_tag,
    output logic [spq_pkg::CNT_W-1:0]          o_occupancy
);

    logic [spq_pkg::PRIO_BITS-1:0] r_slot_prio [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::TAG_BITS-1:0]  r_slot_tag  [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::PRIO_BITS-1:0] n_slot_prio [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::TAG_BITS-1:0]  n_slot_tag  [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::QUEUE_DEPTH-1:0] w_after;
    logic [spq_pkg::CNT_W-1:0]     r_count;
    logic [spq_pkg::CNT_W-1:0]     n_count;
    logic [spq_pkg::STAT_W-1:0]    r_status;
    logic [spq_pkg::TAG_BITS-1:0]  r_head_tag;
    logic [spq_pkg::CNT_W-1:0]     r_occ;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));

    // An entry stays in place when it is valid and does not rank after the new one.
    always_comb begin
        for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
            w_after[i] = (spq_pkg::CNT_W'(i) < r_count) && (r_slot_prio[i] <= i_prio);
        end
    end

    always_comb begin
        n_slot_prio = r_slot_prio;
        n_slot_tag  = r_slot_tag;
        n_count     = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + spq_pkg::CNT_W'(1);
            if (!w_after[0]) begin
                n_slot_prio[0] = i_prio;
                n_slot_tag[0]  = i_tag;
            end
            for (int i = 1; i < spq_pkg::QUEUE_DEPTH; i++) begin
                if (!w_after[i]) begin
                    if (w_after[i-1]) begin
                        n_slot_prio[i] = i_prio;
                        n_slot_tag[i]  = i_tag;
                    end else begin
                        n_slot_prio[i] = r_slot_prio[i-1];
                        n_slot_tag[i]  = r_slot_tag[i-1];
                    end
                end
            end
        end else if (i_cmd.remove) begin
            n_count = r_count - spq_pkg::CNT_W'(1);
            for (int i = 0; i < spq_pkg::QUEUE_DEPTH - 1; i++) begin
                n_slot_prio[i] = r_slot_prio[i+1];
                n_slot_tag[i]  = r_slot_tag[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_prio <= n_slot_prio;
        r_slot_tag  <= n_slot_tag;
        if (i_cmd.load) begin
            r_status   <= i_cmd.status;
            r_head_tag <= i_cmd.remove ? r_slot_tag[0] : '0;
            r_occ      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_status    = r_status;
    assign o_head_tag  = r_head_tag;
    assign o_occupancy = r_occ;

endmodule

`default_nettype wire

// ----- design/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue
// A bounded sorted queue of priority and tag pairs; equal priorities leave
// in arrival order and smaller values leave first.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on i_req: req_type 0 inserts prio_value and entry_tag,
// req_type 1 removes the head entry. Each transfer on i_req produces exactly
// one transfer on o_rsp carrying status, head_tag and occupancy.
// The response comes from an output register in the cycle after the request
// transfer. All slots compare against the new priority in parallel and shift
// together, so one request can be taken every cycle unless o_rsp stalls.
// A new request is taken while a response is held as long as o_rsp.ready is
// high in the same cycle; when the receiver stalls, i_req.ready drops and the
// held response stays unchanged until it is taken.
// Reset empties the queue and clears any held response; slot contents are
// not cleared, since slots at or above the fill count are never read.
// An insert into a full queue is dropped with status 2; a remove on an empty
// queue returns status 1. head_tag is zero except for a successful remove.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    spq_pkg::t_dp_cmd  w_cmd;
    spq_pkg::t_dp_stat w_stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid)
    );

    spq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_prio      (i_req.prio_value),
        .i_tag       (i_req.entry_tag),
        .o_stat      (w_stat),
        .o_status    (o_rsp.status),
        .o_head_tag  (o_rsp.head_tag),
        .o_occupancy (o_rsp.occupancy)
    );

endmodule

`default_nettype wire

// ----- tb/sv/spq_order_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue response checker
// Watches the request and response channels. Every request transfer is run
// through a shadow copy of the sorted queue, and the response it should give
// is queued. Each response transfer is compared field by field with the
// oldest queued response, and every mismatch is counted.
// ----------------------------------------------------------------------------
module spq_order_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_req_type,
    input  logic [spq_pkg::PRIO_BITS-1:0] i_prio_value,
    input  logic [spq_pkg::TAG_BITS-1:0]  i_entry_tag,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic [spq_pkg::STAT_W-1:0]    i_status,
    input  logic [spq_pkg::TAG_BITS-1:0]  i_head_tag,
    input  logic [spq_pkg::CNT_W-1:0]     i_occupancy,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        spq_pkg::t_status                status;
        logic [spq_pkg::TAG_BITS-1:0]    head_tag;
        logic [spq_pkg::CNT_W-1:0]       occupancy;
    } t_queue_rsp;

    logic [spq_pkg::PRIO_BITS-1:0] shadow_prio [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::TAG_BITS-1:0]  shadow_tag  [spq_pkg::QUEUE_DEPTH];
    int                            shadow_fill = 0;
    t_queue_rsp                    due_rsp [$];
    int                            mismatch_total = 0;
    int                            due_count = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = due_count;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic t_queue_rsp apply_request(
        input logic                          kind,
        input logic [spq_pkg::PRIO_BITS-1:0] prio,
        input logic [spq_pkg::TAG_BITS-1:0]  tag
    );
        t_queue_rsp rsp;
        int         pos;
        rsp.status   = spq_pkg::STAT_OK;
        rsp.head_tag = '0;
        if (kind == spq_pkg::REQ_INSERT) begin
            if (shadow_fill >= spq_pkg::QUEUE_DEPTH) begin
                rsp.status = spq_pkg::STAT_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_fill && shadow_prio[pos] <= prio) pos++;
                for (int i = shadow_fill; i > pos; i--) begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_tag[i]  = shadow_tag[i-1];
                end
                shadow_prio[pos] = prio;
                shadow_tag[pos]  = tag;
                shadow_fill++;
            end
        end else if (shadow_fill == 0) begin
            rsp.status = spq_pkg::STAT_EMPTY;
        end else begin
            rsp.head_tag = shadow_tag[0];
            for (int i = 1; i < shadow_fill; i++) begin
                shadow_prio[i-1] = shadow_prio[i];
                shadow_tag[i-1]  = shadow_tag[i];
            end
            shadow_fill--;
        end
        rsp.occupancy = spq_pkg::CNT_W'(shadow_fill);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_queue_rsp want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            due_rsp.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (due_rsp.size() == 0) begin
                    report_mismatch("response transfer with no request outstanding");
                end else begin
                    want = due_rsp.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status expected %0d got %0d",
                                                  want.status, i_status));
                    end
                    if (i_head_tag !== want.head_tag) begin
                        report_mismatch($sformatf("head_tag expected %h got %h",
                                                  want.head_tag, i_head_tag));
                    end
                    if (i_occupancy !== want.occupancy) begin
                        report_mismatch($sformatf("occupancy expected %0d got %0d",
                                                  want.occupancy, i_occupancy));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                due_rsp.push_back(apply_request(i_req_type, i_prio_value, i_entry_tag));
            end
        end
        due_count = due_rsp.size();
    end

endmodule

// ----- tb/sv/tb_stable_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives requests into the queue and takes its responses, with random idle
// bursts on both channels. A directed part fills the queue past full, tries
// a remove on an empty queue and exercises equal and extreme priorities;
// random segments then push the queue between empty and full with varying
// insert and remove mixes. A separate checker predicts every response.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;

    localparam int RAND_ITEMS  = 950;
    localparam int CALM_ITEMS  = 100;

    localparam logic [spq_pkg::PRIO_BITS-1:0] FILL_PRIO [spq_pkg::QUEUE_DEPTH] =
        '{4'd15, 4'd0, 4'd7, 4'd7, 4'd0, 4'd15, 4'd3, 4'd7,
          4'd0, 4'd15, 4'd8, 4'd1, 4'd7, 4'd14, 4'd2, 4'd15};

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   rsp_stall_on = 1'b0;
    int   fail_count;
    int   pending;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    spq_order_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_type   (req_ch.req_type),
        .i_prio_value (req_ch.prio_value),
        .i_entry_tag  (req_ch.entry_tag),
        .i_rsp_valid  (rsp_ch.valid),
        .i_rsp_ready  (rsp_ch.ready),
        .i_status     (rsp_ch.status),
        .i_head_tag   (rsp_ch.head_tag),
        .i_occupancy  (rsp_ch.occupancy),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_req(input logic kind, input logic [spq_pkg::PRIO_BITS-1:0] prio,
                            input logic [spq_pkg::TAG_BITS-1:0] tag);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.prio_value <= prio;
        req_ch.entry_tag  <= tag;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic idle_req(input int cycles);
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= 1'($urandom);
        req_ch.prio_value <= spq_pkg::PRIO_BITS'($urandom);
        req_ch.entry_tag  <= spq_pkg::TAG_BITS'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rsp_stall_on && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    initial begin
        logic [spq_pkg::TAG_BITS-1:0]  tag;
        logic [spq_pkg::PRIO_BITS-1:0] prio;
        logic                          kind;
        int                            sent;
        int                            seg_len;
        int                            insert_pct;
        bit                            narrow;
        bit                            gaps_on;
        bit                            stalls_on;
        bit                            calm;

        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= spq_pkg::REQ_INSERT;
        req_ch.prio_value <= '0;
        req_ch.entry_tag  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(spq_pkg::REQ_REMOVE, '0, '0);
        for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
            tag = (i == 0) ? 16'h0000 : (i == spq_pkg::QUEUE_DEPTH - 1) ? 16'hFFFF
                : spq_pkg::TAG_BITS'(16'hA500 + i);
            send_req(spq_pkg::REQ_INSERT, FILL_PRIO[i], tag);
        end
        send_req(spq_pkg::REQ_INSERT, '0, 16'hFFFF);
        repeat (5) send_req(spq_pkg::REQ_REMOVE, '1, '1);
        wait_drained();

        sent = 0;
        while (sent < RAND_ITEMS) begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       insert_pct = 20;
                1:       insert_pct = 50;
                default: insert_pct = 80;
            endcase
            narrow    = 1'($urandom_range(0, 1));
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
            end
            for (int k = 0; k < seg_len && sent < RAND_ITEMS; k++) begin
                calm         = (RAND_ITEMS - sent) <= CALM_ITEMS;
                rsp_stall_on = stalls_on && !calm;
                if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
                    idle_req($urandom_range(1, 14));
                end
                kind = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::REQ_INSERT
                                                            : spq_pkg::REQ_REMOVE;
                prio = narrow ? spq_pkg::PRIO_BITS'(5 * $urandom_range(0, 3))
                              : spq_pkg::PRIO_BITS'($urandom_range(0, 15));
                send_req(kind, prio, spq_pkg::TAG_BITS'($urandom));
                sent++;
            end
        end

        rsp_stall_on = 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- stable_priority_queue.f -----
design/spq_pkg.sv
design/spq_if.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/stable_priority_queue.sv
tb/sv/spq_order_checker.sv
tb/sv/tb_stable_priority_queue.sv
